>>> hw/rtl/cup_pkg.sv
// Shared types, codes and the arithmetic helper of the chroma upsampler.
package cup_pkg;

    typedef logic [31:0] t_pair;

    typedef enum logic [1:0] {
        ACT_CHROMA = 2'd0,
        ACT_LUMA   = 2'd1,
        ACT_SOF    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HORIZ_SUB    = 2'd2;
    localparam logic [1:0] CFG_VERT_SUB     = 2'd3;

    typedef struct packed {
        logic [15:0] luma;
        logic        eor;
        logic        eof;
        logic        col_a_odd;
        logic        col_b_odd;
    } t_pix_ctl;

    function automatic t_pair avg_pair(input t_pair a, input t_pair b);
        logic [16:0] su;
        logic [16:0] sv;
        su = {1'b0, a[15:0]} + {1'b0, b[15:0]};
        sv = {1'b0, a[31:16]} + {1'b0, b[31:16]};
        return {sv[16:1], su[16:1]};
    endfunction

endpackage

>>> hw/rtl/cup_in_if.sv
// Input channel interface of the chroma upsampler.
interface cup_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] luma_sample;
    logic [15:0] chroma_u;
    logic [15:0] chroma_v;

    modport source (output valid, action, luma_sample, chroma_u, chroma_v, input ready);
    modport sink (input valid, action, luma_sample, chroma_u, chroma_v, output ready);
endinterface

>>> hw/rtl/cup_out_if.sv
// Output channel interface of the chroma upsampler.
interface cup_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_luma;
    logic [15:0] out_u;
    logic [15:0] out_v;
    logic        end_of_row;
    logic        end_of_frame;

    modport source (output valid, out_luma, out_u, out_v, end_of_row, end_of_frame,
                    input ready);
    modport sink (input valid, out_luma, out_u, out_v, end_of_row, end_of_frame,
                  output ready);
endinterface

>>> hw/rtl/cup_line_store.sv
// Two-row chroma line store split into even and odd column banks.
module cup_line_store
    import cup_pkg::*;
#(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic          i_wr_odd,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pair         i_wr_data,
    input  logic [AW-1:0] i_rd_even_a,
    input  logic [AW-1:0] i_rd_even_b,
    input  logic [AW-1:0] i_rd_odd_a,
    input  logic [AW-1:0] i_rd_odd_b,
    output t_pair         o_even_a,
    output t_pair         o_even_b,
    output t_pair         o_odd_a,
    output t_pair         o_odd_b
);

    localparam int DEPTH = 2 ** AW;

    t_pair mem_even [DEPTH];
    t_pair mem_odd  [DEPTH];
    t_pair r_even_a, r_even_b, r_odd_a, r_odd_b;

    always_ff @(posedge i_clk) begin
        if (i_we && !i_wr_odd) begin
            mem_even[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_even_a <= mem_even[i_rd_even_a];
            r_even_b <= mem_even[i_rd_even_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_wr_odd) begin
            mem_odd[i_wr_addr] <= i_wr_data;
        end
        if (i_en) begin
            r_odd_a <= mem_odd[i_rd_odd_a];
            r_odd_b <= mem_odd[i_rd_odd_b];
        end
    end

    assign o_even_a = r_even_a;
    assign o_even_b = r_even_b;
    assign o_odd_a  = r_odd_a;
    assign o_odd_b  = r_odd_b;

endmodule

>>> hw/rtl/cup_addr_gen.sv
// Configuration, position counters and line store address generation.
module cup_addr_gen
    import cup_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int CW        = 12,
    parameter int IW        = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_accept,
    input  logic [1:0]    i_action,
    input  logic [15:0]   i_luma,
    input  logic [15:0]   i_u,
    input  logic [15:0]   i_v,
    output logic          o_we,
    output logic          o_wr_odd,
    output logic [IW:0]   o_wr_addr,
    output t_pair         o_wr_data,
    output logic [IW:0]   o_rd_even_a,
    output logic [IW:0]   o_rd_even_b,
    output logic [IW:0]   o_rd_odd_a,
    output logic [IW:0]   o_rd_odd_b,
    output logic          o_pix_valid,
    output t_pix_ctl      o_ctl
);

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [12:0]   r_fw;
    logic [15:0]   r_fh;
    logic          r_hs, r_vs;
    logic [CW-1:0] r_wcol, r_pcol;
    logic [15:0]   r_wrow, r_prow;

    logic [WW-1:0] w;
    logic [15:0]   h;
    logic [WW:0]   uvw, wcol_inc, pcol_ext, w_ext;
    logic          wrap, eor, eof;
    logic [CW-1:0] cadj, col_a, col_b, ev_col, od_col;
    logic          slot_a, slot_b;
    logic [14:0]   k;
    logic [IW-1:0] ie, io;
    t_action       act;

    assign act = t_action'(i_action);

    always_comb begin
        if (r_fw == 13'd0) begin
            w = WW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_fw);
        end
        h = (r_fh == 16'd0) ? 16'd1 : r_fh;
    end

    assign w_ext    = {1'b0, w};
    assign uvw      = (w_ext + (WW + 1)'(r_hs)) >> r_hs;
    assign wcol_inc = (WW + 1)'(r_wcol) + 1'b1;
    assign wrap     = wcol_inc >= uvw;
    assign pcol_ext = (WW + 1)'(r_pcol);
    assign eor      = (pcol_ext + 1'b1) >= w_ext;
    assign eof      = eor && ((17'(r_prow) + 17'd1) >= 17'(h));
    assign k        = r_prow[15:1];

    always_comb begin
        if (!w[0] && pcol_ext == w_ext - 1'b1 && r_pcol != '0) begin
            cadj = r_pcol - 1'b1;
        end else begin
            cadj = r_pcol;
        end
        if (!r_hs) begin
            col_a = r_pcol;
            col_b = r_pcol;
        end else if (cadj == '0) begin
            col_a = '0;
            col_b = '0;
        end else if (cadj[0]) begin
            col_a = cadj >> 1;
            col_b = cadj >> 1;
        end else begin
            col_b = cadj >> 1;
            col_a = (cadj >> 1) - 1'b1;
        end
        if (!r_vs) begin
            slot_a = r_prow[0];
            slot_b = r_prow[0];
        end else if (r_prow[0]) begin
            slot_a = r_prow[1];
            slot_b = r_prow[1];
        end else begin
            slot_b = k[0];
            slot_a = (k == 15'd0) ? 1'b0 : ~k[0];
        end
    end

    assign ev_col = col_a[0] ? col_b : col_a;
    assign od_col = col_a[0] ? col_a : col_b;
    assign ie     = IW'(ev_col >> 1);
    assign io     = IW'(od_col >> 1);

    assign o_rd_even_a = {slot_a, ie};
    assign o_rd_even_b = {slot_b, ie};
    assign o_rd_odd_a  = {slot_a, io};
    assign o_rd_odd_b  = {slot_b, io};

    assign o_we      = i_accept && act == ACT_CHROMA;
    assign o_wr_odd  = r_wcol[0];
    assign o_wr_addr = {r_wrow[0], IW'(r_wcol >> 1)};
    assign o_wr_data = {i_v, i_u};

    assign o_pix_valid   = i_accept && act == ACT_LUMA;
    assign o_ctl.luma      = i_luma;
    assign o_ctl.eor       = eor;
    assign o_ctl.eof       = eof;
    assign o_ctl.col_a_odd = col_a[0];
    assign o_ctl.col_b_odd = col_b[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 13'd1;
            r_fh <= 16'd1;
            r_hs <= 1'b1;
            r_vs <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                CFG_HORIZ_SUB:    r_hs <= i_cfg_data[0];
                CFG_VERT_SUB:     r_vs <= i_cfg_data[0];
                default:          r_fw <= r_fw;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcol <= '0;
            r_wrow <= '0;
            r_pcol <= '0;
            r_prow <= '0;
        end else if (i_accept) begin
            case (act)
                ACT_CHROMA: begin
                    if (wrap) begin
                        r_wcol <= '0;
                        r_wrow <= r_wrow + 16'd1;
                    end else begin
                        r_wcol <= r_wcol + 1'b1;
                    end
                end
                ACT_LUMA: begin
                    if (eor) begin
                        r_pcol <= '0;
                        r_prow <= ((17'(r_prow) + 17'd1) >= 17'(h)) ? 16'd0 : r_prow + 16'd1;
                    end else begin
                        r_pcol <= r_pcol + 1'b1;
                    end
                end
                ACT_SOF: begin
                    r_wcol <= '0;
                    r_wrow <= '0;
                    r_pcol <= '0;
                    r_prow <= '0;
                end
                default: r_pcol <= r_pcol;
            endcase
        end
    end

endmodule

>>> hw/rtl/cup_interp.sv
// Horizontal and vertical averaging pipeline with the output register.
module cup_interp
    import cup_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pix_valid,
    input  t_pix_ctl i_ctl,
    input  t_pair    i_even_a,
    input  t_pair    i_even_b,
    input  t_pair    i_odd_a,
    input  t_pair    i_odd_b,
    output logic     o_en,
    cup_out_if.source out_ch
);

    logic     r_s1_valid, r_s2_valid, r_out_valid;
    t_pix_ctl r_s1_ctl, r_s2_ctl;
    t_pair    r_s2_ha, r_s2_hb, r_out_pair;
    logic     r_out_eor, r_out_eof;
    logic [15:0] r_out_luma;
    t_pair    a_ca, a_cb, b_ca, b_cb;

    assign o_en = !r_out_valid || out_ch.ready;

    assign a_ca = r_s1_ctl.col_a_odd ? i_odd_a : i_even_a;
    assign a_cb = r_s1_ctl.col_b_odd ? i_odd_a : i_even_a;
    assign b_ca = r_s1_ctl.col_a_odd ? i_odd_b : i_even_b;
    assign b_cb = r_s1_ctl.col_b_odd ? i_odd_b : i_even_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_s1_valid  <= i_pix_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s1_ctl   <= i_ctl;
            r_s2_ctl   <= r_s1_ctl;
            r_s2_ha    <= avg_pair(a_ca, a_cb);
            r_s2_hb    <= avg_pair(b_ca, b_cb);
            r_out_pair <= avg_pair(r_s2_ha, r_s2_hb);
            r_out_luma <= r_s2_ctl.luma;
            r_out_eor  <= r_s2_ctl.eor;
            r_out_eof  <= r_s2_ctl.eof;
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.out_luma     = r_out_luma;
    assign out_ch.out_u        = r_out_pair[15:0];
    assign out_ch.out_v        = r_out_pair[31:16];
    assign out_ch.end_of_row   = r_out_eor;
    assign out_ch.end_of_frame = r_out_eof;

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_valid)
        else $error("Output valid after reset.");
    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_en) |=> r_s2_valid)
        else $error("Pixel lost between stages.");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> ((r_s2_valid === $past(r_s2_valid)) && (r_s2_ha === $past(r_s2_ha)) &&
                   (r_s2_hb === $past(r_s2_hb))))
        else $error("Stage moved during stall.");
    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eof) |-> r_out_eor)
        else $error("End of frame without end of row.");

endmodule

>>> hw/rtl/chroma_upsampler_420_to_444_top.sv
// Top level of the 4:2:0 to 4:4:4 chroma upsampler.
// The block takes one item per clock, chroma writes, luma pixels and frame
// starts alike, and returns each pixel with its bilinear chroma through the
// line store read registers, the horizontal stage and the output register;
// the pace is set by the two line store banks, each read at two rows per
// cycle so that a pixel's four chroma neighbors arrive together. A stalled
// output stalls the whole pipeline and the input. No clearing pass follows
// reset. Chroma must be written before the luma rows that read it.
module chroma_upsampler_420_to_444_top
    import cup_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    cup_in_if.sink      in_ch,
    cup_out_if.source   out_ch
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int IW = (CW > 1) ? CW - 1 : 1;

    logic          en, accept, we, wr_odd, pix_valid;
    logic [IW:0]   wr_addr, rd_even_a, rd_even_b, rd_odd_a, rd_odd_b;
    t_pair         wr_data, even_a, even_b, odd_a, odd_b;
    t_pix_ctl      ctl;

    assign in_ch.ready = en;
    assign accept      = in_ch.valid && en;

    cup_addr_gen #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .IW(IW)) u_addr (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_accept(accept), .i_action(in_ch.action), .i_luma(in_ch.luma_sample),
        .i_u(in_ch.chroma_u), .i_v(in_ch.chroma_v),
        .o_we(we), .o_wr_odd(wr_odd), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_rd_even_a(rd_even_a), .o_rd_even_b(rd_even_b),
        .o_rd_odd_a(rd_odd_a), .o_rd_odd_b(rd_odd_b),
        .o_pix_valid(pix_valid), .o_ctl(ctl)
    );

    cup_line_store #(.AW(IW + 1)) u_store (
        .i_clk(i_clk), .i_en(en), .i_we(we), .i_wr_odd(wr_odd),
        .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_rd_even_a(rd_even_a), .i_rd_even_b(rd_even_b),
        .i_rd_odd_a(rd_odd_a), .i_rd_odd_b(rd_odd_b),
        .o_even_a(even_a), .o_even_b(even_b), .o_odd_a(odd_a), .o_odd_b(odd_b)
    );

    cup_interp u_interp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix_valid(pix_valid), .i_ctl(ctl),
        .i_even_a(even_a), .i_even_b(even_b), .i_odd_a(odd_a), .i_odd_b(odd_b),
        .o_en(en), .out_ch(out_ch)
    );

endmodule
